>>> design/cttu_pkg.sv
package cttu_pkg;

    localparam int MAX_CHUNKS     = 256;
    localparam int CHUNK_BYTES    = 128;
    localparam int MISSING_REPORT = 5;

    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int BYTES_W = 24;
    localparam int FOUND_W = $clog2(MISSING_REPORT + 1);

    localparam logic [7:0] DLEN_MAX = 8'(CHUNK_BYTES + 10);

    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_CHUNK  = 3'd1;
    localparam logic [2:0] MODE_END    = 3'd2;
    localparam logic [2:0] MODE_CANCEL = 3'd3;
    localparam logic [2:0] MODE_TICK   = 3'd4;

    localparam logic [4:0] ST_STARTED     = 5'd0;
    localparam logic [4:0] ST_CHUNK_OK    = 5'd1;
    localparam logic [4:0] ST_DUP         = 5'd2;
    localparam logic [4:0] ST_COMPLETE    = 5'd3;
    localparam logic [4:0] ST_CANCELLED   = 5'd4;
    localparam logic [4:0] ST_BUSY        = 5'd5;
    localparam logic [4:0] ST_BAD_COUNT   = 5'd6;
    localparam logic [4:0] ST_TOO_LARGE   = 5'd7;
    localparam logic [4:0] ST_NO_SD       = 5'd8;
    localparam logic [4:0] ST_SD_FULL     = 5'd9;
    localparam logic [4:0] ST_FILE_ERR    = 5'd10;
    localparam logic [4:0] ST_NOT_STARTED = 5'd11;
    localparam logic [4:0] ST_BAD_CHUNK   = 5'd12;
    localparam logic [4:0] ST_DECODE_ERR  = 5'd13;
    localparam logic [4:0] ST_WRITE_ERR   = 5'd14;
    localparam logic [4:0] ST_MISSING     = 5'd15;
    localparam logic [4:0] ST_RENAME_ERR  = 5'd16;
    localparam logic [4:0] ST_TIMEOUT     = 5'd17;
    localparam logic [4:0] ST_NONE        = 5'd18;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RECV  = 2'd1;
    localparam logic [1:0] PH_ERROR = 2'd2;

    localparam logic [0:0] CFG_TIMEOUT  = 1'd0;
    localparam logic [0:0] CFG_MAX_SIZE = 1'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_EMIT,
        S_EMIT2,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_FIN
    } state_t;

    typedef enum logic [1:0] {
        EMIT_PEND,
        EMIT_CANCEL,
        EMIT_MISS
    } emit_sel_t;

    typedef struct packed {
        logic      cap;
        logic      exec;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
        logic      clear;
        logic      rd_scan;
        logic      scan_next;
        logic      scan_take;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic two_res;
        logic clear_after;
        logic out_free;
        logic idx_end;
        logic seen;
        logic have_pend;
        logic found_last;
    } stat_t;

endpackage

>>> design/cttu_ram.sv
module cttu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/cttu_ctrl.sv
module cttu_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cttu_pkg::stat_t st,
    output cttu_pkg::cmd_t  cmd
);

    import cttu_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_READ;
            end
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = S_EMIT;
            S_EMIT: begin
                if (st.need_scan) begin
                    state_next = S_SCAN_RD;
                end else if (st.out_free) begin
                    state_next = st.two_res ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                if (st.out_free) state_next = S_IDLE;
            end
            S_SCAN_RD: begin
                state_next = st.idx_end ? S_SCAN_FIN : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (st.seen) begin
                    state_next = S_SCAN_RD;
                end else if (!st.have_pend || st.out_free) begin
                    state_next = st.found_last ? S_SCAN_FIN : S_SCAN_RD;
                end
            end
            S_SCAN_FIN: begin
                if (st.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.emit_sel  = EMIT_PEND;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                cmd.cap = s_valid;
            end
            S_EXEC: cmd.exec = 1'b1;
            S_EMIT: begin
                if (!st.need_scan && st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = !st.two_res;
                    cmd.clear     = st.clear_after;
                end
            end
            S_EMIT2: begin
                cmd.emit_sel  = EMIT_CANCEL;
                cmd.emit_last = 1'b1;
                cmd.emit      = st.out_free;
            end
            S_SCAN_RD: cmd.rd_scan = 1'b1;
            S_SCAN_CHK: begin
                cmd.rd_scan  = 1'b1;
                cmd.emit_sel = EMIT_MISS;
                if (st.seen) begin
                    cmd.scan_next = 1'b1;
                end else if (!st.have_pend || st.out_free) begin
                    // push out the held index, hold the new one until we know if it is last
                    cmd.emit      = st.have_pend;
                    cmd.scan_take = 1'b1;
                    cmd.scan_next = 1'b1;
                end
            end
            S_SCAN_FIN: begin
                cmd.emit_sel  = EMIT_MISS;
                cmd.emit_last = 1'b1;
                cmd.emit      = st.out_free;
            end
            default: ;
        endcase
    end

endmodule

>>> design/cttu_dp.sv
module cttu_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cttu_pkg::cmd_t                  cmd,
    output cttu_pkg::stat_t                 st,
    input  logic [2:0]                      s_mode,
    input  logic [7:0]                      s_chunk_number,
    input  logic [15:0]                     s_chunk_total,
    input  logic [15:0]                     s_expected_size,
    input  logic [7:0]                      s_decoded_length,
    input  logic                            s_sd_ready,
    input  logic                            s_space_ok,
    input  logic                            s_file_ok,
    input  logic                            s_write_ok,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [4:0]                      m_status_code,
    output logic [7:0]                      m_chunk_echo,
    output logic [7:0]                      m_missing_index,
    output logic                            m_last_result,
    output logic [1:0]                      m_phase,
    output logic [cttu_pkg::CNT_W-1:0]      m_received_count,
    output logic [cttu_pkg::CNT_W-1:0]      m_total_count,
    output logic [cttu_pkg::BYTES_W-1:0]    m_received_bytes,
    input  logic                            cfg_wr_en,
    input  logic [0:0]                      cfg_index,
    input  logic [31:0]                     cfg_data
);

    import cttu_pkg::*;

    // captured input word
    logic [2:0]       in_mode_reg;
    logic [IDX_W-1:0] in_cnum_reg;
    logic [15:0]      in_ctot_reg;
    logic [15:0]      in_esize_reg;
    logic [7:0]       in_dlen_reg;
    logic             in_sd_reg, in_space_reg, in_file_reg, in_write_reg;

    logic [31:0] timeout_reg;
    logic [15:0] max_size_reg;

    logic [1:0]            phase_reg, phase_next;
    logic [MAX_CHUNKS-1:0] vld_reg, vld_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [CNT_W-1:0]      received_reg, received_next;
    logic [15:0]           expected_reg, expected_next;
    logic [BYTES_W-1:0]    bytes_reg, bytes_next;
    logic [31:0]           timer_reg, timer_next;

    logic [4:0]       pend_status_reg, pend_status_next;
    logic [7:0]       pend_echo_reg, pend_echo_next;
    logic             need_scan_reg, need_scan_next;
    logic             two_res_reg, two_res_next;
    logic             clear_after_reg, clear_after_next;

    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [FOUND_W-1:0] found_reg, found_next;
    logic               have_pend_reg, have_pend_next;
    logic [IDX_W-1:0]   miss_idx_reg, miss_idx_next;

    logic             out_valid_reg;
    logic [4:0]       out_status_reg;
    logic [7:0]       out_echo_reg, out_miss_reg;
    logic             out_last_reg;
    logic [1:0]       out_phase_reg;
    logic [CNT_W-1:0] out_recv_reg, out_total_reg;
    logic [BYTES_W-1:0] out_bytes_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    logic [0:0]       ram_rdata;

    logic             seen_chunk, seen_scan;
    logic [7:0]       dlen_clamp;
    logic [BYTES_W:0] bytes_sum;
    logic [31:0]      timer_inc;

    cttu_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CHUNKS)
    ) u_seen_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_cnum_reg),
        .wdata (1'b1),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr  = cmd.rd_scan ? scan_idx_reg[IDX_W-1:0] : in_cnum_reg;
    assign seen_chunk = vld_reg[in_cnum_reg] & ram_rdata[0];
    assign seen_scan  = vld_reg[scan_idx_reg[IDX_W-1:0]] & ram_rdata[0];

    assign dlen_clamp = (in_dlen_reg > DLEN_MAX) ? DLEN_MAX : in_dlen_reg;
    assign bytes_sum  = {1'b0, bytes_reg} + (BYTES_W + 1)'(dlen_clamp);
    assign timer_inc  = (timer_reg == '1) ? timer_reg : timer_reg + 32'd1;

    always_comb begin
        phase_next       = phase_reg;
        vld_next         = vld_reg;
        total_next       = total_reg;
        received_next    = received_reg;
        expected_next    = expected_reg;
        bytes_next       = bytes_reg;
        timer_next       = timer_reg;
        pend_status_next = pend_status_reg;
        pend_echo_next   = pend_echo_reg;
        need_scan_next   = need_scan_reg;
        two_res_next     = two_res_reg;
        clear_after_next = clear_after_reg;
        scan_idx_next    = scan_idx_reg;
        found_next       = found_reg;
        have_pend_next   = have_pend_reg;
        miss_idx_next    = miss_idx_reg;
        ram_we           = 1'b0;

        if (cmd.exec) begin
            pend_status_next = ST_NONE;
            pend_echo_next   = 8'd0;
            need_scan_next   = 1'b0;
            two_res_next     = 1'b0;
            clear_after_next = 1'b0;
            scan_idx_next    = '0;
            found_next       = '0;
            have_pend_next   = 1'b0;
            case (in_mode_reg)
                MODE_START: begin
                    if (phase_reg == PH_RECV) begin
                        pend_status_next = ST_BUSY;
                    end else if (in_ctot_reg == 16'd0 || in_ctot_reg > 16'(MAX_CHUNKS)) begin
                        pend_status_next = ST_BAD_COUNT;
                    end else if (in_esize_reg == 16'd0 || in_esize_reg > max_size_reg) begin
                        pend_status_next = ST_TOO_LARGE;
                    end else if (!in_sd_reg) begin
                        pend_status_next = ST_NO_SD;
                    end else if (!in_space_reg) begin
                        pend_status_next = ST_SD_FULL;
                    end else begin
                        vld_next         = '0;
                        total_next       = in_ctot_reg[CNT_W-1:0];
                        expected_next    = in_esize_reg;
                        received_next    = '0;
                        bytes_next       = '0;
                        timer_next       = '0;
                        phase_next       = in_file_reg ? PH_RECV : PH_ERROR;
                        pend_status_next = in_file_reg ? ST_STARTED : ST_FILE_ERR;
                    end
                end
                MODE_CHUNK: begin
                    if (phase_reg != PH_RECV) begin
                        pend_status_next = ST_NOT_STARTED;
                    end else if ({1'b0, in_cnum_reg} >= total_reg) begin
                        pend_status_next = ST_BAD_CHUNK;
                    end else if (seen_chunk) begin
                        pend_status_next = ST_DUP;
                        pend_echo_next   = in_cnum_reg;
                    end else if (in_dlen_reg == 8'd0) begin
                        pend_status_next = ST_DECODE_ERR;
                    end else if (!in_file_reg) begin
                        pend_status_next = ST_FILE_ERR;
                    end else if (!in_write_reg) begin
                        pend_status_next = ST_WRITE_ERR;
                    end else begin
                        ram_we                = 1'b1;
                        vld_next[in_cnum_reg] = 1'b1;
                        received_next         = received_reg + CNT_W'(1);
                        bytes_next            = bytes_sum[BYTES_W] ? '1
                                                                  : bytes_sum[BYTES_W-1:0];
                        timer_next            = '0;
                        pend_status_next      = ST_CHUNK_OK;
                        pend_echo_next        = in_cnum_reg;
                    end
                end
                MODE_END: begin
                    if (phase_reg != PH_RECV) begin
                        pend_status_next = ST_NOT_STARTED;
                    end else if (received_reg < total_reg) begin
                        need_scan_next = 1'b1;
                    end else if (!in_file_reg) begin
                        phase_next       = PH_ERROR;
                        pend_status_next = ST_RENAME_ERR;
                    end else begin
                        phase_next       = PH_IDLE;
                        pend_status_next = ST_COMPLETE;
                        clear_after_next = 1'b1;
                    end
                end
                MODE_CANCEL: begin
                    pend_status_next = (phase_reg == PH_RECV) ? ST_CANCELLED : ST_NONE;
                    phase_next       = PH_IDLE;
                    vld_next         = '0;
                    total_next       = '0;
                    received_next    = '0;
                    expected_next    = '0;
                    bytes_next       = '0;
                    timer_next       = '0;
                end
                MODE_TICK: begin
                    if (phase_reg == PH_RECV) begin
                        timer_next = timer_inc;
                        if (timer_inc > timeout_reg) begin
                            pend_status_next = ST_TIMEOUT;
                            two_res_next     = 1'b1;
                            clear_after_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (cmd.scan_take) begin
            have_pend_next = 1'b1;
            miss_idx_next  = scan_idx_reg[IDX_W-1:0];
            found_next     = found_reg + FOUND_W'(1);
        end
        if (cmd.scan_next) begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end

        // output register samples the old state on the same edge
        if (cmd.clear) begin
            phase_next    = PH_IDLE;
            vld_next      = '0;
            total_next    = '0;
            received_next = '0;
            expected_next = '0;
            bytes_next    = '0;
            timer_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg     <= 32'd60000;
            max_size_reg    <= 16'd65535;
            phase_reg       <= PH_IDLE;
            vld_reg         <= '0;
            total_reg       <= '0;
            received_reg    <= '0;
            expected_reg    <= '0;
            bytes_reg       <= '0;
            timer_reg       <= '0;
            need_scan_reg   <= 1'b0;
            two_res_reg     <= 1'b0;
            clear_after_reg <= 1'b0;
            scan_idx_reg    <= '0;
            found_reg       <= '0;
            have_pend_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                    CFG_MAX_SIZE: max_size_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            phase_reg       <= phase_next;
            vld_reg         <= vld_next;
            total_reg       <= total_next;
            received_reg    <= received_next;
            expected_reg    <= expected_next;
            bytes_reg       <= bytes_next;
            timer_reg       <= timer_next;
            need_scan_reg   <= need_scan_next;
            two_res_reg     <= two_res_next;
            clear_after_reg <= clear_after_next;
            scan_idx_reg    <= scan_idx_next;
            found_reg       <= found_next;
            have_pend_reg   <= have_pend_next;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_status_reg <= pend_status_next;
        pend_echo_reg   <= pend_echo_next;
        miss_idx_reg    <= miss_idx_next;
        if (cmd.cap) begin
            in_mode_reg  <= s_mode;
            in_cnum_reg  <= s_chunk_number;
            in_ctot_reg  <= s_chunk_total;
            in_esize_reg <= s_expected_size;
            in_dlen_reg  <= s_decoded_length;
            in_sd_reg    <= s_sd_ready;
            in_space_reg <= s_space_ok;
            in_file_reg  <= s_file_ok;
            in_write_reg <= s_write_ok;
        end
        if (cmd.emit) begin
            case (cmd.emit_sel)
                EMIT_PEND: begin
                    out_status_reg <= pend_status_reg;
                    out_echo_reg   <= pend_echo_reg;
                    out_miss_reg   <= 8'd0;
                end
                EMIT_CANCEL: begin
                    out_status_reg <= ST_CANCELLED;
                    out_echo_reg   <= 8'd0;
                    out_miss_reg   <= 8'd0;
                end
                EMIT_MISS: begin
                    out_status_reg <= ST_MISSING;
                    out_echo_reg   <= 8'd0;
                    out_miss_reg   <= have_pend_reg ? miss_idx_reg : 8'd0;
                end
                default: begin
                    out_status_reg <= ST_NONE;
                    out_echo_reg   <= 8'd0;
                    out_miss_reg   <= 8'd0;
                end
            endcase
            out_last_reg  <= cmd.emit_last;
            out_phase_reg <= phase_reg;
            out_recv_reg  <= received_reg;
            out_total_reg <= total_reg;
            out_bytes_reg <= bytes_reg;
        end
    end

    always_comb begin
        st             = '0;
        st.need_scan   = need_scan_reg;
        st.two_res     = two_res_reg;
        st.clear_after = clear_after_reg;
        st.out_free    = !out_valid_reg || m_ready;
        st.idx_end     = (scan_idx_reg == total_reg);
        st.seen        = seen_scan;
        st.have_pend   = have_pend_reg;
        st.found_last  = (found_reg == FOUND_W'(MISSING_REPORT - 1));
    end

    assign m_valid          = out_valid_reg;
    assign m_status_code    = out_status_reg;
    assign m_chunk_echo     = out_echo_reg;
    assign m_missing_index  = out_miss_reg;
    assign m_last_result    = out_last_reg;
    assign m_phase          = out_phase_reg;
    assign m_received_count = out_recv_reg;
    assign m_total_count    = out_total_reg;
    assign m_received_bytes = out_bytes_reg;

endmodule

>>> design/chunked_transfer_tracker_unit.sv
// Channel   Ports                     Carries
// input     s_valid / s_ready / s_*   one command word (start, chunk, end, cancel, tick)
// result    m_valid / m_ready / m_*   one status word with a state snapshot
// config    cfg_wr_en / cfg_index     register write, no wait
//
// A command word passes through capture, bitmap read, execute and emit from one accept
// to the next; a tick that times out also emits a second result, a cancel. An end with
// chunks outstanding walks the bitmap RAM, a read and a check state per index, up to
// the chunk total, and stops after the fifth missing index.
// Reset is synchronous and active low; it clears the bitmap valid flags at once,
// no clearing pass. A stalled result holds the sequencer before the next emit;
// s_ready rises again once the last result of a word sits in the output register.
module chunked_transfer_tracker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [7:0]  s_chunk_number,
    input  logic [15:0] s_chunk_total,
    input  logic [15:0] s_expected_size,
    input  logic [7:0]  s_decoded_length,
    input  logic        s_sd_ready,
    input  logic        s_space_ok,
    input  logic        s_file_ok,
    input  logic        s_write_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_status_code,
    output logic [7:0]  m_chunk_echo,
    output logic [7:0]  m_missing_index,
    output logic        m_last_result,
    output logic [1:0]  m_phase,
    output logic [8:0]  m_received_count,
    output logic [8:0]  m_total_count,
    output logic [23:0] m_received_bytes,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    import cttu_pkg::*;

    cmd_t  cmd;
    stat_t st;

    cttu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    cttu_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .st               (st),
        .s_mode           (s_mode),
        .s_chunk_number   (s_chunk_number),
        .s_chunk_total    (s_chunk_total),
        .s_expected_size  (s_expected_size),
        .s_decoded_length (s_decoded_length),
        .s_sd_ready       (s_sd_ready),
        .s_space_ok       (s_space_ok),
        .s_file_ok        (s_file_ok),
        .s_write_ok       (s_write_ok),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status_code    (m_status_code),
        .m_chunk_echo     (m_chunk_echo),
        .m_missing_index  (m_missing_index),
        .m_last_result    (m_last_result),
        .m_phase          (m_phase),
        .m_received_count (m_received_count),
        .m_total_count    (m_total_count),
        .m_received_bytes (m_received_bytes),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

endmodule

>>> test/transfer_status_checker.sv
module transfer_status_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [7:0]  s_chunk_number,
    input  logic [15:0] s_chunk_total,
    input  logic [15:0] s_expected_size,
    input  logic [7:0]  s_decoded_length,
    input  logic        s_sd_ready,
    input  logic        s_space_ok,
    input  logic        s_file_ok,
    input  logic        s_write_ok,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [4:0]  m_status_code,
    input  logic [7:0]  m_chunk_echo,
    input  logic [7:0]  m_missing_index,
    input  logic        m_last_result,
    input  logic [1:0]  m_phase,
    input  logic [8:0]  m_received_count,
    input  logic [8:0]  m_total_count,
    input  logic [23:0] m_received_bytes,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          words_pending,
    output int          status_words_seen
);

    import cttu_pkg::*;

    typedef struct packed {
        logic [4:0]  status;
        logic [7:0]  echo;
        logic [7:0]  miss;
        logic        last;
        logic [1:0]  phase;
        logic [8:0]  rcvd;
        logic [8:0]  total;
        logic [23:0] nbytes;
    } status_word_t;

    status_word_t expected_words[$];
    status_word_t staged[$];

    // shadow of the transfer state and the registers
    logic [1:0]            phase_q;
    logic [MAX_CHUNKS-1:0] seen_map;
    logic [8:0]            total_q;
    logic [8:0]            rcvd_q;
    logic [15:0]           size_q;
    logic [23:0]           bytes_q;
    logic [31:0]           ticks_q;
    logic [31:0]           timeout_cfg;
    logic [15:0]           max_size_cfg;

    initial begin
        mismatches = 0;
        words_pending = 0;
        status_words_seen = 0;
    end

    function automatic void drop_transfer();
        phase_q = PH_IDLE;
        seen_map = '0;
        total_q = '0;
        rcvd_q = '0;
        size_q = '0;
        bytes_q = '0;
        ticks_q = '0;
    endfunction

    function automatic void stage(input logic [4:0] st, input logic [7:0] echo,
                                  input logic [7:0] miss);
        status_word_t w;
        w.status = st;
        w.echo = echo;
        w.miss = miss;
        w.last = 1'b0;
        w.phase = phase_q;
        w.rcvd = rcvd_q;
        w.total = total_q;
        w.nbytes = bytes_q;
        staged.push_back(w);
    endfunction

    function automatic void predict_status_words(
        input logic [2:0]  mode,
        input logic [7:0]  cnum,
        input logic [15:0] ctot,
        input logic [15:0] esize,
        input logic [7:0]  dlen,
        input logic        sd_ok,
        input logic        room_ok,
        input logic        fs_ok,
        input logic        wr_ok
    );
        status_word_t w;
        int found;
        logic [7:0] len;
        staged.delete();
        found = 0;
        case (mode)
            MODE_START: begin
                if (phase_q == PH_RECV) stage(ST_BUSY, 8'd0, 8'd0);
                else if (ctot == 0 || ctot > MAX_CHUNKS) stage(ST_BAD_COUNT, 8'd0, 8'd0);
                else if (esize == 0 || esize > max_size_cfg) stage(ST_TOO_LARGE, 8'd0, 8'd0);
                else if (!sd_ok) stage(ST_NO_SD, 8'd0, 8'd0);
                else if (!room_ok) stage(ST_SD_FULL, 8'd0, 8'd0);
                else begin
                    seen_map = '0;
                    total_q = ctot[8:0];
                    size_q = esize;
                    rcvd_q = '0;
                    bytes_q = '0;
                    ticks_q = '0;
                    phase_q = fs_ok ? PH_RECV : PH_ERROR;
                    stage(fs_ok ? ST_STARTED : ST_FILE_ERR, 8'd0, 8'd0);
                end
            end
            MODE_CHUNK: begin
                if (phase_q != PH_RECV) stage(ST_NOT_STARTED, 8'd0, 8'd0);
                else if (9'(cnum) >= total_q) stage(ST_BAD_CHUNK, 8'd0, 8'd0);
                else if (seen_map[cnum]) stage(ST_DUP, cnum, 8'd0);
                else if (dlen == 0) stage(ST_DECODE_ERR, 8'd0, 8'd0);
                else if (!fs_ok) stage(ST_FILE_ERR, 8'd0, 8'd0);
                else if (!wr_ok) stage(ST_WRITE_ERR, 8'd0, 8'd0);
                else begin
                    // clamp to the decoder limit
                    len = (dlen > DLEN_MAX) ? DLEN_MAX : dlen;
                    seen_map[cnum] = 1'b1;
                    rcvd_q = rcvd_q + 9'd1;
                    if (~bytes_q < 24'(len)) bytes_q = '1;
                    else bytes_q = bytes_q + 24'(len);
                    ticks_q = '0;
                    stage(ST_CHUNK_OK, cnum, 8'd0);
                end
            end
            MODE_END: begin
                if (phase_q != PH_RECV) stage(ST_NOT_STARTED, 8'd0, 8'd0);
                else if (rcvd_q < total_q) begin
                    for (int i = 0; i < int'(total_q) && found < MISSING_REPORT; i++) begin
                        if (!seen_map[i]) begin
                            stage(ST_MISSING, 8'd0, 8'(i));
                            found++;
                        end
                    end
                    if (found == 0) stage(ST_MISSING, 8'd0, 8'd0);
                end else if (!fs_ok) begin
                    phase_q = PH_ERROR;
                    stage(ST_RENAME_ERR, 8'd0, 8'd0);
                end else begin
                    // report the finished counts, then clear
                    phase_q = PH_IDLE;
                    stage(ST_COMPLETE, 8'd0, 8'd0);
                    drop_transfer();
                end
            end
            MODE_CANCEL: begin
                w.status = (phase_q == PH_RECV) ? ST_CANCELLED : ST_NONE;
                drop_transfer();
                stage(w.status, 8'd0, 8'd0);
            end
            MODE_TICK: begin
                if (phase_q == PH_RECV) begin
                    if (ticks_q != '1) ticks_q = ticks_q + 32'd1;
                    if (ticks_q > timeout_cfg) begin
                        stage(ST_TIMEOUT, 8'd0, 8'd0);
                        drop_transfer();
                        stage(ST_CANCELLED, 8'd0, 8'd0);
                    end else begin
                        stage(ST_NONE, 8'd0, 8'd0);
                    end
                end else begin
                    stage(ST_NONE, 8'd0, 8'd0);
                end
            end
            default: stage(ST_NONE, 8'd0, 8'd0);
        endcase
        w = staged.pop_back();
        w.last = 1'b1;
        staged.push_back(w);
        foreach (staged[i]) expected_words.push_back(staged[i]);
    endfunction

    function automatic int field_bad(input string name, input int unsigned want,
                                     input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        status_word_t w;
        if (!aresetn) begin
            timeout_cfg = 32'd60000;
            max_size_cfg = 16'hFFFF;
            drop_transfer();
            expected_words.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TIMEOUT:  timeout_cfg = cfg_data;
                    CFG_MAX_SIZE: max_size_cfg = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                status_words_seen++;
                if (expected_words.size() == 0) begin
                    $error("status word with nothing expected: status %0d", m_status_code);
                    mismatches++;
                end else begin
                    w = expected_words.pop_front();
                    mismatches += field_bad("status_code", w.status, m_status_code);
                    mismatches += field_bad("chunk_echo", w.echo, m_chunk_echo);
                    mismatches += field_bad("missing_index", w.miss, m_missing_index);
                    mismatches += field_bad("last_result", w.last, m_last_result);
                    mismatches += field_bad("phase", w.phase, m_phase);
                    mismatches += field_bad("received_count", w.rcvd, m_received_count);
                    mismatches += field_bad("total_count", w.total, m_total_count);
                    mismatches += field_bad("received_bytes", w.nbytes, m_received_bytes);
                end
            end
            if (s_valid && s_ready)
                predict_status_words(s_mode, s_chunk_number, s_chunk_total, s_expected_size,
                                     s_decoded_length, s_sd_ready, s_space_ok, s_file_ok,
                                     s_write_ok);
        end
        words_pending = expected_words.size();
    end

endmodule

>>> test/chunked_transfer_tracker_unit_test.sv
module chunked_transfer_tracker_unit_test;
    import cttu_pkg::*;

    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_mode = MODE_TICK;
    logic [7:0]  s_chunk_number = '0;
    logic [15:0] s_chunk_total = '0;
    logic [15:0] s_expected_size = '0;
    logic [7:0]  s_decoded_length = '0;
    logic        s_sd_ready = 1'b0;
    logic        s_space_ok = 1'b0;
    logic        s_file_ok = 1'b0;
    logic        s_write_ok = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_status_code;
    logic [7:0]  m_chunk_echo;
    logic [7:0]  m_missing_index;
    logic        m_last_result;
    logic [1:0]  m_phase;
    logic [8:0]  m_received_count;
    logic [8:0]  m_total_count;
    logic [23:0] m_received_bytes;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = CFG_TIMEOUT;
    logic [31:0] cfg_data = '0;

    int mismatches;
    int words_pending;
    int status_words_seen;
    int words_sent = 0;
    int max_size_now = 65535;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    chunked_transfer_tracker_unit dut (.*);

    transfer_status_checker status_check (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(idle_on && $urandom_range(99) < 37);
            end
        end
    end

    task automatic send_word(input logic [2:0] mode, input logic [7:0] cnum,
                             input logic [15:0] ctot, input logic [15:0] esize,
                             input logic [7:0] dlen, input logic sd, input logic sp,
                             input logic fo, input logic wo);
        while (idle_on && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_chunk_number <= cnum;
        s_chunk_total <= ctot;
        s_expected_size <= esize;
        s_decoded_length <= dlen;
        s_sd_ready <= sd;
        s_space_ok <= sp;
        s_file_ok <= fo;
        s_write_ok <= wo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (mode <= MODE_TICK) words_sent++;
    endtask

    task automatic send_noise();
        send_word(3'($urandom_range(7)), 8'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // drain all expected words, then let the sequencer run idle before the next phase
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_transfer();
        int n;
        int pick;
        int sends;
        int slot;
        int tmp;
        int order[MAX_CHUNKS];
        logic [7:0] dlen;
        pick = $urandom_range(99);
        if (pick < 65) n = $urandom_range(8, 1);
        else if (pick < 90) n = $urandom_range(40, 9);
        else n = $urandom_range(MAX_CHUNKS, 200);
        for (int i = 0; i < n; i++) order[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            slot = $urandom_range(i);
            tmp = order[i];
            order[i] = order[slot];
            order[slot] = tmp;
        end
        send_word(MODE_START, 8'($urandom), 16'(n), 16'($urandom_range(max_size_now, 1)),
                  8'($urandom), $urandom_range(24) != 0, $urandom_range(24) != 0,
                  $urandom_range(24) != 0, 1'($urandom));
        // big transfers get only a handful of chunks before the end scan
        sends = (n > 40) ? $urandom_range(8, 3) : n;
        for (int k = 0; k < sends; k++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                repeat ($urandom_range(12, 1))
                    send_word(MODE_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                              8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                              1'($urandom));
            end else if (pick < 9 && n < MAX_CHUNKS) begin
                send_word(MODE_CHUNK, 8'($urandom_range(255, n)), 16'($urandom),
                          16'($urandom), 8'($urandom_range(138, 1)), 1'($urandom),
                          1'($urandom), 1'b1, 1'b1);
            end else if (pick < 13) begin
                send_word(MODE_CHUNK, 8'(order[$urandom_range(k)]), 16'($urandom),
                          16'($urandom), 8'($urandom_range(138, 1)), 1'($urandom),
                          1'($urandom), 1'b1, 1'b1);
            end else if (pick < 15) begin
                send_word(MODE_START, 8'($urandom), 16'($urandom), 16'($urandom),
                          8'($urandom), 1'b1, 1'b1, 1'b1, 1'($urandom));
            end
            pick = $urandom_range(99);
            if (pick < 3) dlen = 8'd0;
            else if (pick < 8) dlen = 8'($urandom_range(255, 139));
            else dlen = 8'($urandom_range(138, 1));
            send_word(MODE_CHUNK, 8'(order[k]), 16'($urandom), 16'($urandom), dlen,
                      1'($urandom), 1'($urandom), $urandom_range(49) != 0,
                      $urandom_range(49) != 0);
        end
        pick = $urandom_range(99);
        if (pick < 80)
            send_word(MODE_END, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom), $urandom_range(14) != 0, 1'($urandom));
        if (pick >= 50)
            send_word(MODE_CANCEL, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic run_until(input int goal);
        while (words_sent < goal) begin
            if ($urandom_range(9) == 0) send_noise();
            else run_transfer();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // commands with no open transfer
        send_word(MODE_END, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_CHUNK, 8'd3, 16'd0, 16'd0, 8'd10, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_CANCEL, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_word(MODE_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_word(MODE_UNUSED_HI, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
        // start refusals, in priority order
        send_word(MODE_START, 8'd0, 16'd0, 16'd100, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_START, 8'd0, 16'd257, 16'd100, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_START, 8'd0, 16'd4, 16'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_START, 8'd0, 16'd4, 16'd100, 8'd0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_word(MODE_START, 8'd0, 16'd4, 16'd100, 8'd0, 1'b1, 1'b0, 1'b1, 1'b1);
        // temp file failure leaves the block in error
        send_word(MODE_START, 8'd0, 16'd4, 16'd100, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1);
        send_word(MODE_CHUNK, 8'd0, 16'd0, 16'd0, 8'd5, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_START, 8'd0, 16'd256, 16'hFFFF, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_START, 8'd0, 16'd2, 16'd10, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_CHUNK, 8'd255, 16'd0, 16'd0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_CHUNK, 8'd255, 16'd0, 16'd0, 8'd1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_CHUNK, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_CHUNK, 8'd0, 16'd0, 16'd0, 8'd9, 1'b1, 1'b1, 1'b0, 1'b1);
        send_word(MODE_CHUNK, 8'd0, 16'd0, 16'd0, 8'd9, 1'b1, 1'b1, 1'b1, 1'b0);
        send_word(MODE_CHUNK, 8'd0, 16'd0, 16'd0, 8'd1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_END, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_CANCEL, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        // one-chunk transfer: bad index, rename failure, then a clean completion
        send_word(MODE_START, 8'd0, 16'd1, 16'd1, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_CHUNK, 8'd1, 16'd0, 16'd0, 8'd7, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_CHUNK, 8'd0, 16'd0, 16'd0, DLEN_MAX, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_END, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1);
        send_word(MODE_END, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_START, 8'd0, 16'd1, 16'd1, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_CHUNK, 8'd0, 16'd0, 16'd0, 8'd64, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(MODE_END, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        settle();

        // shortest timeout: a second tick already expires the transfer
        write_reg(CFG_TIMEOUT, 32'd1);
        write_reg(CFG_MAX_SIZE, 32'd65535);
        run_until(words_sent + 90);
        settle();

        // widest timeout, smallest size limit, no idling on either side
        idle_on = 1'b0;
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_SIZE, 32'd1);
        max_size_now = 1;
        run_until(words_sent + 80);
        settle();

        idle_on = 1'b1;
        max_size_now = $urandom_range(65535, 1000);
        write_reg(CFG_TIMEOUT, 32'($urandom_range(12, 3)));
        write_reg(CFG_MAX_SIZE, 32'(max_size_now));
        hold_req = 1'b1;
        run_until(430);
        settle();

        $display("Sent %0d command words and checked %0d status words over four register",
                 words_sent, status_words_seen);
        $display("settings, including a 400-cycle result stall.");
        if (mismatches == 0 && words_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
